### hdl/iirl_pkg.sv
// Shared constants, codes and the cell command type of the indexed list.
`timescale 1ns / 1ps
`default_nettype none
package iirl_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int CNT_OUT_W = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_REPLACE = 3'd2,
    OP_READ    = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic              shift_up;
    logic              shift_down;
    logic              wr;
    logic [CMP_W-1:0]  pos;
    logic [CMP_W-1:0]  used;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage
`default_nettype wire

### hdl/iirl_cell.sv
// One list entry that loads the new word or takes a neighbor's entry.
`timescale 1ns / 1ps
`default_nettype none
module iirl_cell (
  input  wire logic                      clk,
  input  wire logic [iirl_pkg::CMP_W-1:0]  idx,
  input  wire iirl_pkg::cell_cmd_t       cmd,
  input  wire logic [iirl_pkg::DATA_W-1:0] left_data,
  input  wire logic [iirl_pkg::DATA_W-1:0] right_data,
  output logic      [iirl_pkg::DATA_W-1:0] data
);
  import iirl_pkg::*;

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.shift_up) begin
      if (idx == cmd.pos) begin
        data_nxt = cmd.value;
      end else if ((idx > cmd.pos) && (idx <= cmd.used)) begin
        data_nxt = left_data;
      end
    end else if (cmd.shift_down) begin
      if ((idx >= cmd.pos) && ((idx + CMP_W'(1)) < cmd.used)) begin
        data_nxt = right_data;
      end
    end else if (cmd.wr) begin
      if (idx == cmd.pos) begin
        data_nxt = cmd.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule
`default_nettype wire

### hdl/indexed_insert_remove_list.sv
// Top level of the indexed insert/remove list built from a row of entry cells.
// Latency: a result is valid in the cycle after its transaction is accepted.
// Throughput: one item per cycle while out_ready holds; every cell of the row updates
// in the same cycle, so insert and remove shift the whole list at once.
// Reset clears the entry count and the result valid flag; entry words are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module indexed_insert_remove_list (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [2:0]                     in_func,
  input  wire logic [iirl_pkg::POS_W-1:0]     in_position,
  input  wire logic signed [iirl_pkg::DATA_W-1:0] in_item_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [1:0]                          out_status,
  output logic signed [iirl_pkg::DATA_W-1:0]  out_read_value,
  output logic [iirl_pkg::CNT_OUT_W-1:0]      out_count,
  output logic                                out_empty_res
);
  import iirl_pkg::*;

  logic [CNT_W-1:0]  used_r;
  logic [CNT_W-1:0]  used_nxt;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [DATA_W-1:0] out_read_value_r;
  logic [CNT_W-1:0]  out_count_r;

  logic              accept;
  op_t               op;
  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  used_c;
  status_t           status_nxt;
  logic [DATA_W-1:0] rd_nxt;
  logic              up;
  logic              down;
  logic              wr;
  cell_cmd_t         cmd;
  logic [DATA_W-1:0] entry [CAPACITY];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign op       = op_t'(in_func);
  assign pos_c    = CMP_W'(in_position);
  assign used_c   = CMP_W'(used_r);

  always_comb begin
    status_nxt = ST_OK;
    rd_nxt     = '0;
    used_nxt   = used_r;
    up         = 1'b0;
    down       = 1'b0;
    wr         = 1'b0;
    case (op)
      OP_INSERT: begin
        if (pos_c > used_c) begin
          status_nxt = ST_RANGE;
        end else if (used_c >= CMP_W'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else begin
          up       = 1'b1;
          used_nxt = used_r + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (pos_c >= used_c) begin
          status_nxt = ST_RANGE;
        end else begin
          down     = 1'b1;
          used_nxt = used_r - CNT_W'(1);
        end
      end
      OP_REPLACE: begin
        if (pos_c >= used_c) begin
          status_nxt = ST_RANGE;
        end else begin
          wr = 1'b1;
        end
      end
      OP_READ: begin
        if (pos_c >= used_c) begin
          status_nxt = ST_RANGE;
        end else begin
          rd_nxt = entry[pos_c[IDX_W-1:0]];
        end
      end
      OP_CLEAR: begin
        used_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd.shift_up   = accept && up;
    cmd.shift_down = accept && down;
    cmd.wr         = accept && wr;
    cmd.pos        = pos_c;
    cmd.used       = used_c;
    cmd.value      = in_item_value;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = in_item_value;
    end else begin : g_mid_l
      assign left_d = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = entry[i+1];
    end
    iirl_cell u_cell (
      .clk        (clk),
      .idx        (CMP_W'(i)),
      .cmd        (cmd),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (entry[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        used_r      <= used_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r     <= status_nxt;
      out_read_value_r <= rd_nxt;
      out_count_r      <= used_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = CNT_OUT_W'(out_count_r);
  assign out_empty_res  = (out_count_r == '0);

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid && (out_count_r == used_r)))
    else $error("accepted transaction gave no matching result");

  a_full_only_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_FULL)) |-> (out_count_r == CNT_W'(CAPACITY)))
    else $error("full status while list not full");

  a_failed_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (status_nxt != ST_OK)) |=> $stable(used_r))
    else $error("failed operation changed the entry count");

endmodule
`default_nettype wire
